### rtl/dtp_pkg.sv
// Shared types, character codes and calendar constants for the date text parser.
`default_nettype none

package dtp_pkg;

  typedef struct packed {
    logic [15:0]        full_year;
    logic [15:0]        month_number;
    logic signed [16:0] day_number;
    logic [2:0]         weekday;
    logic [8:0]         year_day;
    logic               date_ok;
  } result_t;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  localparam int YEAR_PIVOT  = 1000;
  localparam int YEAR_OFFSET = 2000;
  localparam int YEAR_MIN    = 1831;
  localparam int YEAR_MAX    = 11899;
  localparam int MONTH_MAX   = 12;
  localparam int DAY_MAX     = 31;
  localparam int SAT16_MAX   = 65535;

  // floor(x / 25) = (x * RECIP) >> SHIFT, exact over the operand range used
  localparam int RECIP25_Q       = 41944;
  localparam int RECIP25_Q_SHIFT = 20;
  localparam int RECIP25_Y       = 83887;
  localparam int RECIP25_Y_SHIFT = 21;
  // floor(x / 7) for x below 2^15
  localparam int RECIP7          = 37450;
  localparam int RECIP7_SHIFT    = 18;
  // epoch and -473 offsets folded modulo 7
  localparam int WEEKDAY_BIAS    = 6;

  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
    logic [8:0] base;
    unique case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && m >= 4'd2 && m <= 4'd11) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

`default_nettype wire

### rtl/date_text_parse_weekday.sv
// Date text parser top level: queue-style byte input, queue-style result output.
//
// Bytes of a year-month-day text enter on push/full, one per cycle while full
// is low. A beat with last_char_i set closes the text: the three parsed fields
// go into a small record queue and the parser is back at its reset state for
// the next byte in the following cycle, so texts may follow back to back.
// A four-stage calendar pipeline takes one record per cycle from that queue
// and writes year, month, signed day, weekday, day of year and the valid flag
// into a result queue. Each result passes the record queue, four pipeline
// registers and the result queue to the output ports; empty low means the
// head result is valid and pop takes it. Sustained rate is one byte per cycle.
// When the receiver stops popping, the pipeline issues only while the result
// queue has room for everything in flight; once that and the record queue
// fill up, full rises and input stalls. Nothing is dropped.
// Reset clears the parser state, both queues and the pipeline valid bits.
`default_nettype none

module date_text_parse_weekday #(
  parameter int ACC_WIDTH = 16,
  parameter int REC_DEPTH = 4,
  parameter int RES_DEPTH = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         char_code_i,
  input  wire logic               last_char_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic [15:0]             full_year_o,
  output logic [15:0]             month_number_o,
  output logic signed [16:0]      day_number_o,
  output logic [2:0]              weekday_o,
  output logic [8:0]              year_day_o,
  output logic                    date_ok_o
);

  localparam int RW = 3 * ACC_WIDTH + 1;
  localparam int OW = $bits(dtp_pkg::result_t);

  logic                         accept;
  logic                         rec_push;
  logic [RW-1:0]                rec_wdata;
  logic [RW-1:0]                rec_rdata;
  logic                         rec_pop;
  logic                         rec_full;
  logic                         rec_empty;
  logic [$clog2(REC_DEPTH):0]   rec_count;
  logic                         res_push;
  dtp_pkg::result_t             res_wdata;
  logic [OW-1:0]                res_rdata;
  logic                         res_full;
  logic [$clog2(RES_DEPTH):0]   res_count;
  dtp_pkg::result_t             res_head;

  assign full   = rec_full;
  assign accept = push && !rec_full;

  dtp_front #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .rec_push_o  (rec_push),
    .rec_data_o  (rec_wdata)
  );

  dtp_fifo #(
    .WIDTH (RW),
    .DEPTH (REC_DEPTH)
  ) u_rec_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .wdata_i (rec_wdata),
    .pop_i   (rec_pop),
    .rdata_o (rec_rdata),
    .full_o  (rec_full),
    .empty_o (rec_empty),
    .count_o (rec_count)
  );

  dtp_back #(
    .ACC_WIDTH (ACC_WIDTH),
    .RES_DEPTH (RES_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (!rec_empty),
    .rec_data_i  (rec_rdata),
    .rec_pop_o   (rec_pop),
    .res_count_i (res_count),
    .res_push_o  (res_push),
    .res_data_o  (res_wdata)
  );

  dtp_fifo #(
    .WIDTH (OW),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_wdata),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .full_o  (res_full),
    .empty_o (empty),
    .count_o (res_count)
  );

  assign res_head       = res_rdata;
  assign full_year_o    = res_head.full_year;
  assign month_number_o = res_head.month_number;
  assign day_number_o   = res_head.day_number;
  assign weekday_o      = res_head.weekday;
  assign year_day_o     = res_head.year_day;
  assign date_ok_o      = res_head.date_ok;

  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result beat written into a full result queue");

  a_last_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && last_char_i && !rec_pop) |=> (rec_count == ($past(rec_count) + 1'b1)))
    else $error("final byte did not queue a record");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !date_ok_o) |-> (weekday_o == 3'd0 && year_day_o == 9'd0))
    else $error("invalid date carries nonzero weekday or day of year");

  a_valid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && date_ok_o) |-> (weekday_o <= 3'd6 && year_day_o <= 9'd365))
    else $error("weekday or day of year out of range");

endmodule

`default_nettype wire

### rtl/dtp_fifo.sv
// Small first-in first-out queue with occupancy count; DEPTH is a power of two.
`default_nettype none

module dtp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     pop_i,
  output logic      [WIDTH-1:0]         rdata_o,
  output logic                          full_o,
  output logic                          empty_o,
  output logic      [$clog2(DEPTH):0]   count_o
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q;
  logic [PW-1:0]    rptr_q;
  logic [PW:0]      count_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == (PW+1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

### rtl/dtp_front.sv
// Character front end: field tracking and saturating decimal accumulators.
`default_nettype none

module dtp_front #(
  parameter int ACC_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   accept_i,
  input  wire logic [7:0]             char_code_i,
  input  wire logic                   last_char_i,
  output logic                        rec_push_o,
  output logic [3*ACC_WIDTH:0]        rec_data_o
);

  typedef enum logic [1:0] {
    FIELD_YEAR,
    FIELD_MONTH,
    FIELD_DAY,
    FIELD_END
  } field_e;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  field_e               field_q, field_d;
  phase_e               phase_q, phase_d;
  logic [ACC_WIDTH-1:0] year_q, year_d;
  logic [ACC_WIDTH-1:0] month_q, month_d;
  logic [ACC_WIDTH-1:0] day_q, day_d;
  logic                 neg_q, neg_d;
  logic                 is_digit;
  logic                 is_blank;
  logic                 is_sep;
  logic                 grow;
  logic [ACC_WIDTH-1:0] acc_cur;
  logic [ACC_WIDTH-1:0] acc_next;

  function automatic logic [ACC_WIDTH-1:0] sat_push(input logic [ACC_WIDTH-1:0] acc,
                                                    input logic [3:0] digit);
    logic [ACC_WIDTH+3:0] s;
    s = ({4'b0000, acc} << 3) + ({4'b0000, acc} << 1) + (ACC_WIDTH+4)'(digit);
    if (|s[ACC_WIDTH+3:ACC_WIDTH]) begin
      return '1;
    end
    return s[ACC_WIDTH-1:0];
  endfunction

  assign is_digit = (char_code_i >= dtp_pkg::CH_ZERO) && (char_code_i <= dtp_pkg::CH_NINE);
  assign is_blank = ((char_code_i >= dtp_pkg::CH_TAB) && (char_code_i <= dtp_pkg::CH_CR)) ||
                    (char_code_i == dtp_pkg::CH_SPACE);
  assign is_sep   = (char_code_i == dtp_pkg::CH_SLASH) || (char_code_i == dtp_pkg::CH_MINUS);

  always_comb begin
    unique case (field_q)
      FIELD_YEAR:  acc_cur = year_q;
      FIELD_MONTH: acc_cur = month_q;
      default:     acc_cur = day_q;
    endcase
  end

  assign acc_next = sat_push(acc_cur, char_code_i[3:0]);

  always_comb begin
    field_d = field_q;
    phase_d = phase_q;
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    neg_d   = neg_q;
    grow    = 1'b0;
    if (accept_i && field_q != FIELD_END) begin
      if (char_code_i == dtp_pkg::CH_NUL) begin
        field_d = FIELD_END;
      end else if (field_q != FIELD_DAY && is_sep) begin
        field_d = (field_q == FIELD_YEAR) ? FIELD_MONTH : FIELD_DAY;
        phase_d = PH_SKIP;
      end else begin
        unique case (phase_q)
          PH_SKIP: begin
            if (is_blank) begin
              phase_d = PH_SKIP;
            end else if (char_code_i == dtp_pkg::CH_PLUS) begin
              phase_d = PH_DIGITS;
            end else if (char_code_i == dtp_pkg::CH_MINUS) begin
              neg_d   = 1'b1;
              phase_d = PH_DIGITS;
            end else if (is_digit) begin
              grow    = 1'b1;
              phase_d = PH_DIGITS;
            end else begin
              phase_d = PH_DONE;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              grow = 1'b1;
            end else begin
              phase_d = PH_DONE;
            end
          end
          default: phase_d = phase_q;
        endcase
        if (grow) begin
          unique case (field_q)
            FIELD_YEAR:  year_d  = acc_next;
            FIELD_MONTH: month_d = acc_next;
            default:     day_d   = acc_next;
          endcase
        end
      end
    end
    rec_push_o = accept_i && last_char_i;
    rec_data_o = {neg_d, day_d, month_d, year_d};
    if (accept_i && last_char_i) begin
      field_d = FIELD_YEAR;
      phase_d = PH_SKIP;
      year_d  = '0;
      month_d = '0;
      day_d   = '0;
      neg_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q <= FIELD_YEAR;
      phase_q <= PH_SKIP;
      year_q  <= '0;
      month_q <= '0;
      day_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      field_q <= field_d;
      phase_q <= phase_d;
      year_q  <= year_d;
      month_q <= month_d;
      day_q   <= day_d;
      neg_q   <= neg_d;
    end
  end

endmodule

`default_nettype wire

### rtl/dtp_back.sv
// Calendar back end: four-stage pipeline from parsed fields to weekday and day of year.
`default_nettype none

module dtp_back #(
  parameter int ACC_WIDTH = 16,
  parameter int RES_DEPTH = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       rec_valid_i,
  input  wire logic [3*ACC_WIDTH:0]       rec_data_i,
  output logic                            rec_pop_o,
  input  wire logic [$clog2(RES_DEPTH):0] res_count_i,
  output logic                            res_push_o,
  output dtp_pkg::result_t                res_data_o
);

  localparam int SW  = (ACC_WIDTH + 1 > 17) ? ACC_WIDTH + 1 : 17;
  localparam int OCW = $clog2(RES_DEPTH + 4) + 1;

  function automatic logic [15:0] sat16(input logic [SW-1:0] v);
    return (v > SW'(dtp_pkg::SAT16_MAX)) ? 16'hFFFF : v[15:0];
  endfunction

  // stage valid bits
  logic v1_q, v2_q, v3_q, v4_q;
  logic issue;
  logic [OCW-1:0] occ;

  // stage 1 inputs
  logic [SW-1:0]  y_ext;
  logic [SW-1:0]  fy_raw;
  logic [15:0]    fy_c;
  logic [15:0]    mon_c;
  logic [15:0]    day_c;
  logic           neg_c;
  logic           ok_c;
  logic [3:0]     m_c;
  logic [15:0]    corr_c;

  // stage 1 registers
  logic [15:0]        s1_fy_q, s1_mon_q;
  logic signed [16:0] s1_dnum_q;
  logic [4:0]         s1_day_q;
  logic               s1_ok_q;
  logic [3:0]         s1_m_q;
  logic [13:0]        s1_q_q;

  // stage 2
  logic [29:0]        q_prod;
  logic [32:0]        fy_prod;
  logic [15:0]        s2_fy_q, s2_mon_q;
  logic signed [16:0] s2_dnum_q;
  logic [4:0]         s2_day_q;
  logic               s2_ok_q;
  logic [3:0]         s2_m_q;
  logic [13:0]        s2_q_q;
  logic [9:0]         s2_q25_q;
  logic [11:0]        s2_fy25_q;

  // stage 3
  logic [16:0]        fy25x25;
  logic               div25;
  logic               leap;
  logic [16:0]        sum_c;
  logic [15:0]        s3_fy_q, s3_mon_q;
  logic signed [16:0] s3_dnum_q;
  logic               s3_ok_q;
  logic [14:0]        s3_sum_q;
  logic [8:0]         s3_yd_q;

  // stage 4
  logic [30:0]        wd_prod;
  logic [12:0]        wd_quot;
  logic [15:0]        wd_q7;
  logic [15:0]        wd_rem;
  dtp_pkg::result_t   s4_res_q;

  assign occ   = OCW'(res_count_i) + OCW'(v1_q) + OCW'(v2_q) + OCW'(v3_q) + OCW'(v4_q);
  assign issue = rec_valid_i && (occ < OCW'(RES_DEPTH));
  assign rec_pop_o = issue;

  always_comb begin
    y_ext  = SW'(rec_data_i[ACC_WIDTH-1:0]);
    fy_raw = (y_ext > SW'(dtp_pkg::YEAR_PIVOT)) ? y_ext : y_ext + SW'(dtp_pkg::YEAR_OFFSET);
    fy_c   = sat16(fy_raw);
    mon_c  = sat16(SW'(rec_data_i[2*ACC_WIDTH-1:ACC_WIDTH]));
    day_c  = sat16(SW'(rec_data_i[3*ACC_WIDTH-1:2*ACC_WIDTH]));
    neg_c  = rec_data_i[3*ACC_WIDTH];
    ok_c   = (fy_c >= 16'(dtp_pkg::YEAR_MIN)) && (fy_c <= 16'(dtp_pkg::YEAR_MAX)) &&
             (mon_c >= 16'd1) && (mon_c <= 16'(dtp_pkg::MONTH_MAX)) && !neg_c &&
             (day_c >= 16'd1) && (day_c <= 16'(dtp_pkg::DAY_MAX));
    m_c    = ok_c ? (mon_c[3:0] - 4'd1) : 4'd0;
    corr_c = fy_c - ((m_c < 4'd2) ? 16'd1 : 16'd0);
  end

  assign q_prod  = 30'(s1_q_q) * 30'(dtp_pkg::RECIP25_Q);
  assign fy_prod = 33'(s1_fy_q) * 33'(dtp_pkg::RECIP25_Y);

  always_comb begin
    fy25x25 = {1'b0, s2_fy25_q, 4'b0000} + {2'b00, s2_fy25_q, 3'b000} + {5'b00000, s2_fy25_q};
    div25   = ({1'b0, s2_fy_q} == fy25x25);
    leap    = (s2_fy_q[1:0] == 2'b00) && (!div25 || s2_fy_q[3:0] == 4'b0000);
    sum_c   = 17'(s2_fy_q) + 17'(s2_q_q) +
              17'({s2_q25_q, 2'b00}) + 17'({s2_q25_q, 1'b0}) +
              17'(s2_q25_q >> 2) + 17'(dtp_pkg::month_start(1'b0, s2_m_q)) +
              17'(s2_day_q) + 17'(dtp_pkg::WEEKDAY_BIAS);
  end

  always_comb begin
    wd_prod = 31'(s3_sum_q) * 31'(dtp_pkg::RECIP7);
    wd_quot = wd_prod[30:dtp_pkg::RECIP7_SHIFT];
    wd_q7   = {wd_quot, 3'b000} - {3'b000, wd_quot};
    wd_rem  = {1'b0, s3_sum_q} - wd_q7;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_fy_q   <= fy_c;
    s1_mon_q  <= mon_c;
    s1_dnum_q <= neg_c ? -$signed({1'b0, day_c}) : $signed({1'b0, day_c});
    s1_day_q  <= day_c[4:0];
    s1_ok_q   <= ok_c;
    s1_m_q    <= m_c;
    s1_q_q    <= corr_c[15:2];

    s2_fy_q   <= s1_fy_q;
    s2_mon_q  <= s1_mon_q;
    s2_dnum_q <= s1_dnum_q;
    s2_day_q  <= s1_day_q;
    s2_ok_q   <= s1_ok_q;
    s2_m_q    <= s1_m_q;
    s2_q_q    <= s1_q_q;
    s2_q25_q  <= q_prod[29:dtp_pkg::RECIP25_Q_SHIFT];
    s2_fy25_q <= fy_prod[32:dtp_pkg::RECIP25_Y_SHIFT];

    s3_fy_q   <= s2_fy_q;
    s3_mon_q  <= s2_mon_q;
    s3_dnum_q <= s2_dnum_q;
    s3_ok_q   <= s2_ok_q;
    s3_sum_q  <= sum_c[14:0];
    s3_yd_q   <= dtp_pkg::month_start(leap, s2_m_q) + 9'(s2_day_q) - 9'd1;

    s4_res_q.full_year    <= s3_fy_q;
    s4_res_q.month_number <= s3_mon_q;
    s4_res_q.day_number   <= s3_dnum_q;
    s4_res_q.weekday      <= s3_ok_q ? wd_rem[2:0] : 3'd0;
    s4_res_q.year_day     <= s3_ok_q ? s3_yd_q : 9'd0;
    s4_res_q.date_ok      <= s3_ok_q;
  end

  assign res_push_o = v4_q;
  assign res_data_o = s4_res_q;

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking bench for the date text parser: byte stream in, parsed date records out.

module tb_top;

  localparam int ACC_MAX    = 65535;
  localparam int EPOCH_YEAR = 1970;
  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD  = 900;
  localparam int TAIL_WAIT  = 20;
  localparam int BEAT_BUDGET = 950;
  localparam int CUM_DAYS [0:11] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  typedef enum logic [1:0] {F_YEAR, F_MONTH, F_DAY, F_DONE} field_e;
  typedef enum logic [1:0] {P_BLANK, P_DIGITS, P_SKIP} phase_e;

  typedef struct {
    logic [7:0]  code;
    logic        last;
    int unsigned gap;
    bit          drain;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic [7:0] char_code_i = '0;
  logic last_char_i = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic [15:0] full_year_o, month_number_o;
  logic signed [16:0] day_number_o;
  logic [2:0] weekday_o;
  logic [8:0] year_day_o;
  logic date_ok_o;

  // parser state of the predictor
  field_e      cur_field = F_YEAR;
  phase_e      cur_phase = P_BLANK;
  logic [15:0] year_acc = '0, month_acc = '0, day_acc = '0;
  logic        day_neg = 1'b0;

  beat_t             text_beats[$];
  dtp_pkg::result_t  pending_dates[$];
  logic [7:0]        text_buf[$];
  int          beats_made = 0;
  int          mismatches = 0;
  int          dates_seen = 0;
  int unsigned tx_wait = 0;
  bit          tx_armed = 1'b0;
  int unsigned rx_wait = 0;
  int          idle_cycles = 0;

  date_text_parse_weekday u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .char_code_i    (char_code_i),
    .last_char_i    (last_char_i),
    .empty          (empty),
    .pop            (pop),
    .full_year_o    (full_year_o),
    .month_number_o (month_number_o),
    .day_number_o   (day_number_o),
    .weekday_o      (weekday_o),
    .year_day_o     (year_day_o),
    .date_ok_o      (date_ok_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [15:0] acc_digit(input logic [15:0] acc, input logic [7:0] c);
    int unsigned v;
    v = int'(acc) * 10 + int'(c - dtp_pkg::CH_ZERO);
    return (v > ACC_MAX) ? 16'(ACC_MAX) : 16'(v);
  endfunction

  function automatic void parse_byte(input logic [7:0] c);
    logic is_digit;
    is_digit = (c >= dtp_pkg::CH_ZERO) && (c <= dtp_pkg::CH_NINE);
    if (cur_field == F_DONE) return;
    if (c == dtp_pkg::CH_NUL) begin
      cur_field = F_DONE;
      return;
    end
    if (cur_field != F_DAY && (c == dtp_pkg::CH_SLASH || c == dtp_pkg::CH_MINUS)) begin
      cur_field = field_e'(cur_field + 2'd1);
      cur_phase = P_BLANK;
      return;
    end
    if (cur_phase == P_BLANK) begin
      if ((c >= dtp_pkg::CH_TAB && c <= dtp_pkg::CH_CR) || c == dtp_pkg::CH_SPACE) return;
      cur_phase = P_DIGITS;
      if (c == dtp_pkg::CH_MINUS) begin
        day_neg = 1'b1;
      end else if (is_digit) begin
        case (cur_field)
          F_YEAR:  year_acc = acc_digit(year_acc, c);
          F_MONTH: month_acc = acc_digit(month_acc, c);
          default: day_acc = acc_digit(day_acc, c);
        endcase
      end else if (c != dtp_pkg::CH_PLUS) begin
        cur_phase = P_SKIP;
      end
    end else if (cur_phase == P_DIGITS) begin
      if (!is_digit) begin
        cur_phase = P_SKIP;
      end else begin
        case (cur_field)
          F_YEAR:  year_acc = acc_digit(year_acc, c);
          F_MONTH: month_acc = acc_digit(month_acc, c);
          default: day_acc = acc_digit(day_acc, c);
        endcase
      end
    end
  endfunction

  function automatic dtp_pkg::result_t finish_date();
    dtp_pkg::result_t r;
    int fy, mon, day, m, corr, q, w;
    bit leap, ok;
    fy = (year_acc > dtp_pkg::YEAR_PIVOT) ? int'(year_acc)
                                           : int'(year_acc) + dtp_pkg::YEAR_OFFSET;
    mon = int'(month_acc);
    day = int'(day_acc);
    ok = fy >= dtp_pkg::YEAR_MIN && fy <= dtp_pkg::YEAR_MAX &&
         mon >= 1 && mon <= dtp_pkg::MONTH_MAX &&
         !day_neg && day >= 1 && day <= dtp_pkg::DAY_MAX;
    r = '0;
    r.full_year = fy[15:0];
    r.month_number = mon[15:0];
    r.day_number = day_neg ? 17'(-day) : 17'(day);
    r.date_ok = ok;
    if (ok) begin
      m = mon - 1;
      corr = fy - ((m < 2) ? 1 : 0);
      q = corr / 4;
      w = -473 + 365 * (fy - EPOCH_YEAR) + q - q / 25 + (q / 25) / 4 + CUM_DAYS[m] + day - 1;
      leap = (fy % 4 == 0) && ((fy % 100 != 0) || (fy % 400 == 0));
      r.weekday = 3'(((w % 7) + 7) % 7);
      r.year_day = 9'(CUM_DAYS[m] + ((leap && m >= 2) ? 1 : 0) + day - 1);
    end
    cur_field = F_YEAR;
    cur_phase = P_BLANK;
    year_acc = '0;
    month_acc = '0;
    day_acc = '0;
    day_neg = 1'b0;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic put_num(input int unsigned n, input bit pad);
    put_str(pad ? $sformatf("%02d", n) : $sformatf("%0d", n));
  endtask

  task automatic put_blanks();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    for (int i = 0; i < n; i++)
      text_buf.push_back(($urandom_range(0, 1) == 0) ? dtp_pkg::CH_SPACE :
                         8'(dtp_pkg::CH_TAB + $urandom_range(0, 4)));
  endtask

  task automatic commit_text(input int unsigned gap_max, input bit drain);
    beat_t b;
    for (int i = 0; i < text_buf.size(); i++) begin
      b.code = text_buf[i];
      b.last = (i == text_buf.size() - 1);
      b.gap = $urandom_range(0, gap_max);
      b.drain = drain && (i == 0);
      text_beats.push_back(b);
      beats_made++;
    end
    text_buf.delete();
  endtask

  task automatic random_text(input int idx);
    int kind, pick, pos;
    int unsigned year, month, day;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      pick = $urandom_range(0, 7);
      if (pick < 2) year = $urandom_range(0, 1000);
      else if (pick < 6) year = $urandom_range(1825, 2150);
      else if (pick == 6) year = $urandom_range(1000, 12000);
      else year = $urandom_range(0, 9999999);
      month = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
      pick = $urandom_range(0, 19);
      if (pick == 0) day = $urandom_range(0, 999999);
      else if (pick < 4) day = $urandom_range(0, 40);
      else day = $urandom_range(1, 31);
      put_blanks();
      if ($urandom_range(0, 9) == 0) text_buf.push_back(dtp_pkg::CH_PLUS);
      put_num(year, $urandom_range(0, 3) == 0);
      text_buf.push_back(($urandom_range(0, 1) == 0) ? dtp_pkg::CH_MINUS : dtp_pkg::CH_SLASH);
      put_blanks();
      if ($urandom_range(0, 9) == 0) text_buf.push_back(dtp_pkg::CH_PLUS);
      put_num(month, $urandom_range(0, 1) == 0);
      text_buf.push_back(($urandom_range(0, 1) == 0) ? dtp_pkg::CH_MINUS : dtp_pkg::CH_SLASH);
      put_blanks();
      pick = $urandom_range(0, 9);
      if (pick == 0) text_buf.push_back(dtp_pkg::CH_MINUS);
      else if (pick == 1) text_buf.push_back(dtp_pkg::CH_PLUS);
      put_num(day, $urandom_range(0, 1) == 0);
      if ($urandom_range(0, 5) == 0) text_buf.push_back(8'($urandom_range(32, 126)));
      if (kind == 1) begin
        pos = $urandom_range(0, text_buf.size() - 1);
        if ($urandom_range(0, 1) == 0) text_buf[pos] = 8'($urandom_range(0, 255));
        else text_buf.insert(pos, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 15) == 0)
        text_buf.insert($urandom_range(0, text_buf.size() - 1), dtp_pkg::CH_NUL);
    end
    commit_text(((idx / 8) % 4 == 0) ? 0 : 4, idx == 30 || idx == 80);
  endtask

  // byte driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      tx_wait = 0;
      tx_armed = 1'b0;
    end else begin
      bit fired;
      beat_t nxt;
      fired = push && !full;
      if (fired) begin
        parse_byte(char_code_i);
        if (last_char_i) pending_dates.push_back(finish_date());
      end
      if (!push || fired) begin
        if (text_beats.size() == 0) begin
          push <= 1'b0;
        end else begin
          if (!tx_armed) begin
            tx_wait = text_beats[0].gap;
            tx_armed = 1'b1;
          end
          if (tx_wait > 0) begin
            tx_wait--;
            push <= 1'b0;
          end else if (text_beats[0].drain && pending_dates.size() != 0) begin
            push <= 1'b0;
          end else begin
            nxt = text_beats.pop_front();
            tx_armed = 1'b0;
            push <= 1'b1;
            char_code_i <= nxt.code;
            last_char_i <= nxt.last;
          end
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
      rx_wait = 0;
    end else begin
      dtp_pkg::result_t want;
      if (pop && !empty) begin
        if (pending_dates.size() == 0) begin
          flag_mismatch("result beat with no pending date");
        end else begin
          want = pending_dates.pop_front();
          if (full_year_o !== want.full_year)
            flag_mismatch($sformatf("full_year got %0d want %0d", full_year_o, want.full_year));
          if (month_number_o !== want.month_number)
            flag_mismatch($sformatf("month_number got %0d want %0d",
                                    month_number_o, want.month_number));
          if (day_number_o !== want.day_number)
            flag_mismatch($sformatf("day_number got %0d want %0d",
                                    day_number_o, want.day_number));
          if (weekday_o !== want.weekday)
            flag_mismatch($sformatf("weekday got %0d want %0d", weekday_o, want.weekday));
          if (year_day_o !== want.year_day)
            flag_mismatch($sformatf("year_day got %0d want %0d", year_day_o, want.year_day));
          if (date_ok_o !== want.date_ok)
            flag_mismatch($sformatf("date_ok got %0d want %0d", date_ok_o, want.date_ok));
        end
        dates_seen++;
        if (dates_seen == 25 || dates_seen == 70) rx_wait = LONG_HOLD;
        else rx_wait = ((dates_seen / 40) % 4 == 0) ? 0 : $urandom_range(0, 4);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles = 0;
      end else if (++idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int idx;
    put_str("2024-02-29");
    commit_text(4, 1'b0);
    put_str(" \t+24/+2/ -31x");
    commit_text(4, 1'b0);
    put_str("+-+-7");
    commit_text(4, 1'b0);
    put_str("99999-1-31");
    commit_text(4, 1'b0);
    put_str("-1830/2/31");
    commit_text(4, 1'b0);
    put_str("11899/12/31");
    commit_text(0, 1'b0);
    put_str("1831-1-1");
    commit_text(0, 1'b0);
    put_str("7-");
    text_buf.push_back(dtp_pkg::CH_NUL);
    text_buf.push_back(8'hFF);
    commit_text(4, 1'b0);
    idx = 0;
    while (beats_made < BEAT_BUDGET) begin
      random_text(idx);
      idx++;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (text_beats.size() != 0 || push) @(posedge clk_i);
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (mismatches == 0 && pending_dates.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
rtl/dtp_pkg.sv
rtl/dtp_fifo.sv
rtl/dtp_front.sv
rtl/dtp_back.sv
rtl/date_text_parse_weekday.sv
dv/tb_top.sv
